// ===== hw/rtl/chained_block_allocator_defines.svh =====
// assertion macros for the checker file
`ifndef CHAINED_BLOCK_ALLOCATOR_DEFINES_SVH
`define CHAINED_BLOCK_ALLOCATOR_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define CBA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("chained block allocator check failed");

// next-cycle implication, disabled while reset is asserted
`define CBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("chained block allocator check failed");

`endif

// ===== hw/rtl/cba_pkg.sv =====
`default_nettype none

package cba_pkg;

    localparam int NUM_BLOCKS   = 2048;
    localparam int BLK_W        = $clog2(NUM_BLOCKS);
    localparam int RES_W        = 12;
    localparam int WORD_BITS    = 32;
    localparam int BIT_W        = $clog2(WORD_BITS);
    localparam int NUM_WORDS    = NUM_BLOCKS / WORD_BITS;
    localparam int WORD_W       = $clog2(NUM_WORDS);
    localparam int COUNT_W      = 12;
    localparam int SECTOR_W     = 13;
    localparam int FB_W         = 24;
    localparam int PROD_W       = COUNT_W + SECTOR_W;

    localparam logic [RES_W-1:0]    END_MARK      = RES_W'(NUM_BLOCKS);
    localparam logic [FB_W-1:0]     FB_MAX        = {FB_W{1'b1}};
    localparam logic [SECTOR_W-1:0] SECTOR_RESET  = SECTOR_W'(64);
    localparam logic [COUNT_W-1:0]  COUNT_RESET   = COUNT_W'(NUM_BLOCKS);

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 40;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_EXTEND = 2'd1,
        OP_FREE   = 2'd2,
        OP_NEXT   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOFREE = 2'd1,
        ST_RANGE  = 2'd2,
        ST_SPARE  = 2'd3
    } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/chained_block_allocator.sv =====
// chained block allocator
// input beats: s_axis_tuser carries op, s_axis_tdata carries the block operand.
// each accepted beat gives exactly one output beat on m_axis with the result
// block, a status code and the free space in bytes (free count times sector_bytes).
// cfg_we/cfg_wdata set sector_bytes; write it only while no beat is in flight.
// the free flags live in a 64 x 32 bit memory, the links in a 2048 x 12 bit
// memory, both with registered reads; one beat is worked on at a time.
// steps from input accept to output valid:
//   allocate: scan, then the final step; extend: scan, link, then the final step;
//   the flag memory is scanned one word a cycle from word 0 up to the lowest
//   word with a free block; a full disk or a bad index goes straight to the final step;
//   read successor: link read, final step; free: a link read and write per visited block, then the final step
// after reset a clearing pass over all 2048 blocks sets every link to the end mark
// and every flag to free; s_axis_tready stays low until it finishes.
// the result sits in an output register; a new beat is taken while it waits,
// and the block only stalls at its final step if the previous result is unread.
`default_nettype none

module chained_block_allocator
    import cba_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [SECTOR_W-1:0]   cfg_wdata,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,  // [10:0] block, [15:11] zero
    input  wire logic [1:0]            s_axis_tuser,  // [1:0] op
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]       m_axis_tdata,  // [11:0] result_block, [35:12] free_bytes, [39:36] zero
    output logic [1:0]                 m_axis_tuser   // [1:0] status
);

    typedef enum logic [8:0] {
        S_CLEAR   = 9'b000000001,
        S_IDLE    = 9'b000000010,
        S_SCAN    = 9'b000000100,
        S_LINK    = 9'b000001000,
        S_WALK_RD = 9'b000010000,
        S_WALK_WR = 9'b000100000,
        S_NEXT_RD = 9'b001000000,
        S_FIN     = 9'b010000000,
        S_SPARE   = 9'b100000000
    } state_t;

    // lowest set bit of a flag word, five halving steps
    function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] word);
        logic [WORD_BITS-1:0] v;
        logic [BIT_W-1:0]     idx;
        logic [WORD_BITS-1:0] mask;
        v   = word;
        idx = '0;
        for (int k = BIT_W - 1; k >= 0; k--) begin
            mask = (WORD_BITS'(1) << (1 << k)) - WORD_BITS'(1);
            if ((v & mask) == '0) begin
                idx[k] = 1'b1;
                v      = v >> (1 << k);
            end
        end
        return idx;
    endfunction

    logic [WORD_BITS-1:0] free_mem [NUM_WORDS];
    logic [RES_W-1:0]     chain_mem [NUM_BLOCKS];

    logic                 fm_we;
    logic [WORD_W-1:0]    fm_waddr;
    logic [WORD_BITS-1:0] fm_wdata;
    logic [WORD_W-1:0]    fm_raddr;
    logic [WORD_BITS-1:0] fm_rdata_reg;

    logic                 cm_we;
    logic [BLK_W-1:0]     cm_waddr;
    logic [RES_W-1:0]     cm_wdata;
    logic [BLK_W-1:0]     cm_raddr;
    logic [RES_W-1:0]     cm_rdata_reg;

    state_t               state_reg, state_next;
    op_t                  op_reg, op_next;
    logic [BLK_W-1:0]     blk_reg, blk_next;
    logic [BLK_W-1:0]     cur_reg, cur_next;
    logic [WORD_W-1:0]    scan_reg, scan_next;
    logic [RES_W-1:0]     res_reg, res_next;
    status_t              status_reg, status_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [BLK_W-1:0]     clr_reg, clr_next;
    logic [SECTOR_W-1:0]  sector_reg;

    logic                 out_valid_reg, out_valid_next;
    logic [RES_W-1:0]     out_res_reg;
    logic [FB_W-1:0]      out_fb_reg;
    status_t              out_status_reg;
    logic                 out_load;

    logic                 in_accept;
    logic [BLK_W-1:0]     in_blk;
    logic                 in_range;
    logic [BIT_W-1:0]     found_bit;
    logic [BIT_W-1:0]     cur_bit;
    logic [WORD_BITS-1:0] cur_mask;
    logic [PROD_W-1:0]    prod;
    logic [FB_W-1:0]      fb_sat;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign in_blk    = s_axis_tdata[BLK_W-1:0];
    assign in_range  = {1'b0, in_blk} < END_MARK;
    assign found_bit = lowest_set(fm_rdata_reg);
    assign cur_bit   = cur_reg[BIT_W-1:0];
    assign cur_mask  = WORD_BITS'(1) << cur_bit;
    assign prod      = {{SECTOR_W{1'b0}}, count_reg} * {{COUNT_W{1'b0}}, sector_reg};
    assign fb_sat    = (prod > PROD_W'(FB_MAX)) ? FB_MAX : prod[FB_W-1:0];

    assign s_axis_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        blk_next    = blk_reg;
        cur_next    = cur_reg;
        scan_next   = scan_reg;
        res_next    = res_reg;
        status_next = status_reg;
        count_next  = count_reg;
        clr_next    = clr_reg;
        out_load    = 1'b0;

        fm_we    = 1'b0;
        fm_waddr = '0;
        fm_wdata = '0;
        fm_raddr = '0;
        cm_we    = 1'b0;
        cm_waddr = '0;
        cm_wdata = END_MARK;
        cm_raddr = '0;

        case (state_reg)
            S_CLEAR:
            begin
                cm_we    = 1'b1;
                cm_waddr = clr_reg;
                fm_we    = 1'b1;
                fm_waddr = clr_reg[BLK_W-1:BIT_W];
                fm_wdata = '1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == BLK_W'(NUM_BLOCKS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    op_next     = op_t'(s_axis_tuser);
                    blk_next    = in_blk;
                    cur_next    = in_blk;
                    res_next    = END_MARK;
                    status_next = ST_OK;
                    scan_next   = '0;
                    fm_raddr    = in_blk[BLK_W-1:BIT_W];
                    cm_raddr    = in_blk;
                    if (op_t'(s_axis_tuser) != OP_ALLOC && !in_range)
                    begin
                        status_next = ST_RANGE;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        case (op_t'(s_axis_tuser))
                            OP_ALLOC, OP_EXTEND:
                            begin
                                fm_raddr = '0;
                                if (count_reg == '0)
                                begin
                                    status_next = ST_NOFREE;
                                    state_next  = S_FIN;
                                end
                                else
                                begin
                                    state_next = S_SCAN;
                                end
                            end
                            OP_FREE: state_next = S_WALK_WR;
                            OP_NEXT: state_next = S_NEXT_RD;
                            default: state_next = S_FIN;
                        endcase
                    end
                end
            end
            S_SCAN:
            begin
                if (fm_rdata_reg != '0)
                begin
                    res_next   = RES_W'({scan_reg, found_bit});
                    fm_we      = 1'b1;
                    fm_waddr   = scan_reg;
                    fm_wdata   = fm_rdata_reg & ~(WORD_BITS'(1) << found_bit);
                    cm_we      = 1'b1;
                    cm_waddr   = {scan_reg, found_bit};
                    cm_wdata   = END_MARK;
                    count_next = count_reg - 1'b1;
                    state_next = (op_reg == OP_EXTEND) ? S_LINK : S_FIN;
                end
                else
                begin
                    // free count is nonzero, so some later word has a free block
                    scan_next = scan_reg + 1'b1;
                    fm_raddr  = scan_reg + 1'b1;
                end
            end
            S_LINK:
            begin
                cm_we      = 1'b1;
                cm_waddr   = blk_reg;
                cm_wdata   = res_reg;
                state_next = S_FIN;
            end
            S_WALK_RD:
            begin
                fm_raddr   = cur_reg[BLK_W-1:BIT_W];
                cm_raddr   = cur_reg;
                state_next = S_WALK_WR;
            end
            S_WALK_WR:
            begin
                // link is reset before moving on, so a loop ends at the revisited block
                cm_we    = 1'b1;
                cm_waddr = cur_reg;
                cm_wdata = END_MARK;
                fm_we    = 1'b1;
                fm_waddr = cur_reg[BLK_W-1:BIT_W];
                fm_wdata = fm_rdata_reg | cur_mask;
                if ((fm_rdata_reg & cur_mask) == '0)
                begin
                    count_next = count_reg + 1'b1;
                end
                if (cm_rdata_reg >= END_MARK)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cur_next   = cm_rdata_reg[BLK_W-1:0];
                    state_next = S_WALK_RD;
                end
            end
            S_NEXT_RD:
            begin
                res_next   = cm_rdata_reg;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            count_reg     <= COUNT_RESET;
            sector_reg    <= SECTOR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                sector_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        blk_reg    <= blk_next;
        cur_reg    <= cur_next;
        scan_reg   <= scan_next;
        res_reg    <= res_next;
        status_reg <= status_next;
        if (out_load)
        begin
            out_res_reg    <= res_reg;
            out_status_reg <= status_reg;
            out_fb_reg     <= fb_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fm_we)
        begin
            free_mem[fm_waddr] <= fm_wdata;
        end
        fm_rdata_reg <= free_mem[fm_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cm_we)
        begin
            chain_mem[cm_waddr] <= cm_wdata;
        end
        cm_rdata_reg <= chain_mem[cm_raddr];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W - FB_W - RES_W){1'b0}}, out_fb_reg, out_res_reg};
    assign m_axis_tuser  = out_status_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/cba_checker.sv =====
`default_nettype none
`include "chained_block_allocator_defines.svh"

module cba_checker
    import cba_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_axis_tvalid,
    input wire logic                 s_axis_tready,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [M_TDATA_W-1:0] m_axis_tdata,
    input wire logic [1:0]           m_axis_tuser
);

    // a stalled output beat holds its payload
    `CBA_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // one beat at a time: ready drops right after an accept
    `CBA_ASSERT_NEXT(a_one_in_flight, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // results never point past the end mark and never use the spare status
    `CBA_ASSERT_IMPL(a_res_range, clk, rst_n, m_axis_tvalid, m_axis_tdata[RES_W-1:0] <= END_MARK && m_axis_tuser != ST_SPARE)

    // a full disk answers the end mark with no free space
    `CBA_ASSERT_IMPL(a_full_disk, clk, rst_n, m_axis_tvalid && m_axis_tuser == ST_NOFREE, m_axis_tdata[RES_W-1:0] == END_MARK && m_axis_tdata[RES_W+FB_W-1:RES_W] == '0)

endmodule

bind chained_block_allocator cba_checker u_cba_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
